[sv/intel_hex_record_encoder_macros.svh]
// Assertion macros used by the top-level encoder file.
`ifndef INTEL_HEX_RECORD_ENCODER_MACROS_SVH
`define INTEL_HEX_RECORD_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IHEX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ihex_enc_pkg.sv]
`timescale 1ns / 1ps
package ihex_enc_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_ADDRESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDRESS_FORMAT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTE_COUNT     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_RECORD_LEN = 2'd3;

   localparam logic [31:0] BASE_ADDRESS_RESET   = 32'd0;
   localparam logic        ADDRESS_FORMAT_RESET = 1'b0;
   localparam logic [31:0] BYTE_COUNT_RESET     = 32'd1;
   localparam logic [7:0]  MAX_RECORD_LEN_RESET = 8'd32;

   localparam logic [7:0] TYPE_SUM_LINEAR  = 8'h06;
   localparam logic [7:0] TYPE_SUM_SEGMENT = 8'h04;

   localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
   localparam logic [6:0] CHAR_COLON   = 7'h3A;
   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_ONE     = 7'h31;
   localparam logic [6:0] CHAR_TWO     = 7'h32;
   localparam logic [6:0] CHAR_FOUR    = 7'h34;
   localparam logic [6:0] CHAR_F       = 7'h46;

   localparam int QUEUE_DEPTH_DEF = 4;

   // Which pieces of text one transaction produces, in emission order.
   typedef struct packed {
      logic held_nl;   // newline of the end record left over from the previous byte
      logic ext;       // extended address record
      logic hdr;       // data record header
      logic dat;       // the data byte as a hex pair
      logic trl;       // record checksum and newline
      logic endr;      // end record up to its newline
      logic endnl;     // final newline of the end record
   } flags_type;

   typedef struct packed {
      flags_type   flags;
      logic [7:0]  data;
      logic [7:0]  len;
      logic [15:0] addr_lo;
      logic [15:0] upper;
      logic        linear;
      logic [7:0]  ext_ck;
      logic [7:0]  trl_ck;
   } cmd_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h37 + {3'b000, nib});
   endfunction

   // Nibble k of a 16-bit value, most significant first.
   function automatic logic [3:0] nib16(input logic [15:0] v, input logic [1:0] k);
      logic [3:0] n;
      unique case (k)
         2'd0: n = v[15:12];
         2'd1: n = v[11:8];
         2'd2: n = v[7:4];
         2'd3: n = v[3:0];
         default: n = v[3:0];
      endcase
      nib16 = n;
   endfunction

endpackage

[sv/ihex_enc_front.sv]
`timescale 1ns / 1ps
module ihex_enc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ihex_enc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                          csr_data,
   output logic                                 cmd_push,
   output ihex_enc_pkg::cmd_type                cmd,
   input  logic                                 queue_full
);
   import ihex_enc_pkg::*;

   logic [31:0] base_ff, base_in;
   logic        fmt_ff, fmt_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  maxlen_ff, maxlen_in;

   logic        started_ff, started_in;
   logic        finished_ff, finished_in;
   logic        held_ff, held_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] seen_ff, seen_in;
   logic [31:0] rem_ff, rem_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  ck_ff, ck_in;

   logic        accept, csr_write;
   logic [31:0] a_eff, r_eff, r_new;
   logic [15:0] s_eff, upper;
   logic [7:0]  l_eff, c_eff, limit, len, ck_start, ck_new, left_new, ext_sum;
   logic        fin_eff, end_only, do_data, new_rec, ext, trailer, last_byte, overflow;
   flags_type   flags;

   // A register write takes the cycle, so no byte is accepted beside it.
   assign req_ready = !queue_full && !csr_valid;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign csr_write = csr_valid && csr_ready;

   // A new run starts from the register values; otherwise the running state applies.
   assign a_eff   = started_ff ? addr_ff : base_ff;
   assign r_eff   = started_ff ? rem_ff : count_ff;
   assign s_eff   = started_ff ? seen_ff : 16'd0;
   assign l_eff   = started_ff ? left_ff : 8'd0;
   assign c_eff   = started_ff ? ck_ff : 8'd0;
   assign fin_eff = started_ff && finished_ff;

   assign end_only = !started_ff && (count_ff == 32'd0);
   assign do_data  = !fin_eff && (r_eff != 32'd0);
   assign new_rec  = (l_eff == 8'd0);

   assign limit = (maxlen_ff == 8'd0) ? 8'd1 : maxlen_ff;
   assign len   = (r_eff < {24'd0, limit}) ? r_eff[7:0] : limit;
   assign upper = fmt_ff ? a_eff[31:16] : {a_eff[19:16], 12'h000};
   assign ext   = new_rec && (|a_eff[31:16]) && (upper != s_eff);

   assign ck_start = len + a_eff[7:0] + a_eff[15:8];
   assign ck_new   = (new_rec ? ck_start : c_eff) + req_data_byte;
   assign left_new = (new_rec ? len : l_eff) - 8'd1;
   assign trailer  = (left_new == 8'd0);
   assign r_new    = r_eff - 32'd1;
   assign last_byte = (r_new == 32'd0);
   assign ext_sum  = (fmt_ff ? TYPE_SUM_LINEAR : TYPE_SUM_SEGMENT) + upper[7:0] + upper[15:8];

   // The one case of 42 characters: the end record's newline moves to the next byte.
   assign overflow = do_data && ext && trailer && last_byte;

   always_comb begin
      flags.held_nl = held_ff;
      flags.ext     = do_data && ext;
      flags.hdr     = do_data && new_rec;
      flags.dat     = do_data;
      flags.trl     = do_data && trailer;
      flags.endr    = end_only || (do_data && last_byte);
      flags.endnl   = (end_only || (do_data && last_byte)) && !overflow;
   end

   always_comb begin
      cmd.flags   = flags;
      cmd.data    = req_data_byte;
      cmd.len     = len;
      cmd.addr_lo = a_eff[15:0];
      cmd.upper   = upper;
      cmd.linear  = fmt_ff;
      cmd.ext_ck  = 8'd0 - ext_sum;
      cmd.trl_ck  = 8'd0 - ck_new;
   end

   assign cmd_push = accept && !csr_write && (|flags);

   always_comb begin
      base_in     = base_ff;
      fmt_in      = fmt_ff;
      count_in    = count_ff;
      maxlen_in   = maxlen_ff;
      started_in  = started_ff;
      finished_in = finished_ff;
      held_in     = held_ff;
      addr_in     = addr_ff;
      seen_in     = seen_ff;
      rem_in      = rem_ff;
      left_in     = left_ff;
      ck_in       = ck_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BASE_ADDRESS:   base_in   = csr_data;
            REG_ADDRESS_FORMAT: fmt_in    = csr_data[0];
            REG_BYTE_COUNT:     count_in  = csr_data;
            REG_MAX_RECORD_LEN: maxlen_in = csr_data[7:0];
            default:            base_in   = base_ff;
         endcase
         started_in  = 1'b0;
         finished_in = 1'b0;
         held_in     = 1'b0;
      end else if (accept) begin
         started_in  = 1'b1;
         finished_in = fin_eff || end_only || (do_data && last_byte);
         held_in     = overflow;
         addr_in     = a_eff;
         seen_in     = s_eff;
         rem_in      = r_eff;
         left_in     = l_eff;
         ck_in       = c_eff;
         if (do_data) begin
            addr_in = a_eff + 32'd1;
            rem_in  = r_new;
            left_in = left_new;
            ck_in   = ck_new;
            if (ext) begin
               seen_in = upper;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= BASE_ADDRESS_RESET;
         fmt_ff      <= ADDRESS_FORMAT_RESET;
         count_ff    <= BYTE_COUNT_RESET;
         maxlen_ff   <= MAX_RECORD_LEN_RESET;
         started_ff  <= 1'b0;
         finished_ff <= 1'b0;
         held_ff     <= 1'b0;
      end else begin
         base_ff     <= base_in;
         fmt_ff      <= fmt_in;
         count_ff    <= count_in;
         maxlen_ff   <= maxlen_in;
         started_ff  <= started_in;
         finished_ff <= finished_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      seen_ff <= seen_in;
      rem_ff  <= rem_in;
      left_ff <= left_in;
      ck_ff   <= ck_in;
   end

endmodule

[sv/ihex_enc_queue.sv]
`timescale 1ns / 1ps
module ihex_enc_queue #(
   parameter int Depth = ihex_enc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ihex_enc_pkg::cmd_type push_data,
   input  logic                  pop,
   output ihex_enc_pkg::cmd_type head,
   output logic                  head_valid,
   output logic                  full
);
   import ihex_enc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type              slot_ff [Depth];
   logic [PtrW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == CntW'(Depth));
   assign head       = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[sv/ihex_enc_back.sv]
`timescale 1ns / 1ps
module ihex_enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  ihex_enc_pkg::cmd_type cmd_head,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_ascii_char,
   output logic                  rsp_last_of_run,
   output logic                  rsp_end_of_file
);
   import ihex_enc_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_HELD  = 8'b0000_0010,
      S_EXT   = 8'b0000_0100,
      S_HDR   = 8'b0000_1000,
      S_DAT   = 8'b0001_0000,
      S_TRL   = 8'b0010_0000,
      S_ENDR  = 8'b0100_0000,
      S_ENDNL = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in, head_first;
   flags_type  pend_ff, pend_in;
   cmd_type    cur_ff, cur_in;
   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       eof_ff, eof_in;
   logic       advance, phase_done;

   function automatic state_type first_phase(input flags_type f);
      state_type s;
      priority if (f.held_nl) s = S_HELD;
      else if (f.ext)         s = S_EXT;
      else if (f.hdr)         s = S_HDR;
      else if (f.dat)         s = S_DAT;
      else if (f.trl)         s = S_TRL;
      else if (f.endr)        s = S_ENDR;
      else if (f.endnl)       s = S_ENDNL;
      else                    s = S_IDLE;
      first_phase = s;
   endfunction

   function automatic flags_type drop_phase(input flags_type f, input state_type s);
      flags_type r;
      r = f;
      unique case (s)
         S_HELD:  r.held_nl = 1'b0;
         S_EXT:   r.ext     = 1'b0;
         S_HDR:   r.hdr     = 1'b0;
         S_DAT:   r.dat     = 1'b0;
         S_TRL:   r.trl     = 1'b0;
         S_ENDR:  r.endr    = 1'b0;
         S_ENDNL: r.endnl   = 1'b0;
         S_IDLE:  r = f;
         default: r = f;
      endcase
      drop_phase = r;
   endfunction

   function automatic logic [3:0] last_index(input state_type s);
      logic [3:0] n;
      unique case (s)
         S_EXT:   n = 4'd15;
         S_HDR:   n = 4'd8;
         S_DAT:   n = 4'd1;
         S_TRL:   n = 4'd2;
         S_ENDR:  n = 4'd10;
         S_HELD, S_ENDNL, S_IDLE: n = 4'd0;
         default: n = 4'd0;
      endcase
      last_index = n;
   endfunction

   function automatic logic [6:0] char_of(input state_type s, input logic [3:0] i,
                                          input cmd_type c);
      logic [6:0] ch;
      logic [3:0] k_ext, k_hdr;
      k_ext = i - 4'd9;
      k_hdr = i - 4'd3;
      ch = CHAR_ZERO;
      unique case (s)
         S_EXT: begin
            if (i == 4'd0) ch = CHAR_COLON;
            else if (i == 4'd2) ch = CHAR_TWO;
            else if (i == 4'd8) ch = c.linear ? CHAR_FOUR : CHAR_TWO;
            else if (i >= 4'd9 && i <= 4'd12) ch = hex_char(nib16(c.upper, k_ext[1:0]));
            else if (i == 4'd13) ch = hex_char(c.ext_ck[7:4]);
            else if (i == 4'd14) ch = hex_char(c.ext_ck[3:0]);
            else if (i == 4'd15) ch = CHAR_NEWLINE;
         end
         S_HDR: begin
            if (i == 4'd0) ch = CHAR_COLON;
            else if (i == 4'd1) ch = hex_char(c.len[7:4]);
            else if (i == 4'd2) ch = hex_char(c.len[3:0]);
            else if (i >= 4'd3 && i <= 4'd6) ch = hex_char(nib16(c.addr_lo, k_hdr[1:0]));
         end
         S_DAT:   ch = (i == 4'd0) ? hex_char(c.data[7:4]) : hex_char(c.data[3:0]);
         S_TRL: begin
            if (i == 4'd0) ch = hex_char(c.trl_ck[7:4]);
            else if (i == 4'd1) ch = hex_char(c.trl_ck[3:0]);
            else ch = CHAR_NEWLINE;
         end
         S_ENDR: begin
            if (i == 4'd0) ch = CHAR_COLON;
            else if (i == 4'd8) ch = CHAR_ONE;
            else if (i == 4'd9 || i == 4'd10) ch = CHAR_F;
         end
         S_HELD, S_ENDNL: ch = CHAR_NEWLINE;
         S_IDLE:  ch = CHAR_ZERO;
         default: ch = CHAR_ZERO;
      endcase
      char_of = ch;
   endfunction

   assign advance    = !valid_ff || rsp_ready;
   assign phase_done = (idx_ff == last_index(state_ff));
   assign head_first = first_phase(cmd_head.flags);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      eof_in   = eof_ff;
      cmd_pop  = 1'b0;
      if (state_ff == S_IDLE) begin
         if (advance) begin
            valid_in = 1'b0;
         end
         if (cmd_valid) begin
            cmd_pop  = 1'b1;
            cur_in   = cmd_head;
            state_in = head_first;
            pend_in  = drop_phase(cmd_head.flags, head_first);
            idx_in   = 4'd0;
         end
      end else if (advance) begin
         valid_in = 1'b1;
         char_in  = char_of(state_ff, idx_ff, cur_ff);
         last_in  = phase_done && !(|pend_ff);
         eof_in   = (state_ff == S_HELD) || (state_ff == S_ENDNL);
         if (!phase_done) begin
            idx_in = idx_ff + 4'd1;
         end else if (|pend_ff) begin
            state_in = first_phase(pend_ff);
            pend_in  = drop_phase(pend_ff, first_phase(pend_ff));
            idx_in   = 4'd0;
         end else if (cmd_valid) begin
            cmd_pop  = 1'b1;
            cur_in   = cmd_head;
            state_in = head_first;
            pend_in  = drop_phase(cmd_head.flags, head_first);
            idx_in   = 4'd0;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= '0;
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      char_ff <= char_in;
      last_ff <= last_in;
      eof_ff  <= eof_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_ascii_char  = char_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_end_of_file = eof_ff;

endmodule

[sv/intel_hex_record_encoder.sv]
// The first character of a byte passes the command queue, the sequencer state and the output register.
// One character per cycle while the sink is ready; a byte yields 0 to 41 characters,
// about 2.4 on average with 32-byte records, all from the single character sequencer.
// Bytes are accepted every cycle while the command queue has room and no write is offered.
// Reset is synchronous and active high; registers return to their documented reset values.
`timescale 1ns / 1ps
`include "intel_hex_record_encoder_macros.svh"
module intel_hex_record_encoder #(
   parameter int QueueDepth = ihex_enc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [6:0]                           rsp_ascii_char,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_end_of_file,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ihex_enc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                          csr_data
);
   import ihex_enc_pkg::*;

   // The front half owns the registers and the run state. For each accepted byte it
   // decides which pieces of text are due (extended record, header, data pair,
   // checksum, end record) and pushes one command with the precomputed checksums.
   // Bytes that produce no text are consumed without a command.
   cmd_type push_cmd, head_cmd;
   logic    push, pop, head_valid, queue_full;

   ihex_enc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd_push      (push),
      .cmd           (push_cmd),
      .queue_full    (queue_full)
   );

   // The queue lets the front keep taking bytes while the back is still spelling out
   // a long record start.
   ihex_enc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_cmd),
      .pop        (pop),
      .head       (head_cmd),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   // The back half walks the pieces of each command into an output register, one character
   // per cycle while the sink is ready, and loads the next command on the last character without a gap.
   ihex_enc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (head_valid),
      .cmd_head        (head_cmd),
      .cmd_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_file (rsp_end_of_file)
   );

   // The end-of-file marker only ever sits on a newline that closes the byte's text.
   `IHEX_ASSERT_NOW(a_eof_newline, rsp_valid && rsp_end_of_file, (rsp_ascii_char == CHAR_NEWLINE) && rsp_last_of_run, "end of file flag on a character other than the closing newline")

   // Only hex digits, the colon and the newline are ever produced.
   `IHEX_ASSERT_NOW(a_char_set, rsp_valid, ((rsp_ascii_char >= 7'h30) && (rsp_ascii_char <= 7'h3A)) || ((rsp_ascii_char >= 7'h41) && (rsp_ascii_char <= 7'h46)) || (rsp_ascii_char == CHAR_NEWLINE), "character outside the record alphabet")

   // A pushed command cannot vanish before the back half has seen it.
   `IHEX_ASSERT_NEXT(a_push_visible, push && !queue_full, head_valid, "queue empty right after a command was pushed")

endmodule

[dv/ihex_text_checker.sv]
`timescale 1ns / 1ps
module ihex_text_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [6:0]                           rsp_ascii_char,
   input  logic                                 rsp_last_of_run,
   input  logic                                 rsp_end_of_file,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ihex_enc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                          csr_data,
   output int                                   fail_count,
   output int                                   outstanding
);
   import ihex_enc_pkg::*;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
      logic       eof;
   } text_char_type;

   localparam int MAX_CHARS_PER_BYTE = 41;

   logic [31:0] cfg_base;
   logic        cfg_linear;
   logic [31:0] cfg_count;
   logic [7:0]  cfg_max_len;

   logic [31:0] cur_addr;
   logic [15:0] upper_seen;
   logic [31:0] bytes_left;
   logic [7:0]  rec_left;
   logic [7:0]  rec_sum;
   bit          run_active;
   bit          run_done;

   text_char_type line_buf[$];
   text_char_type held_text[$];
   text_char_type expected_text[$];
   text_char_type want;
   int            errors;

   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      return 7'(nib) + ((nib > 4'd9) ? 7'h37 : 7'h30);
   endfunction

   function automatic void put_char(input logic [6:0] c, input logic eof);
      line_buf.push_back('{ch: c, last: 1'b0, eof: eof});
   endfunction

   function automatic void put_hex(input logic [7:0] v);
      put_char(hex_digit(v[7:4]), 1'b0);
      put_char(hex_digit(v[3:0]), 1'b0);
   endfunction

   function automatic void put_text(input string s);
      for (int k = 0; k < s.len(); k++) put_char(7'(s.getc(k)), 1'b0);
   endfunction

   function automatic void put_end_record();
      put_text(":00000001FF");
      put_char(CHAR_NEWLINE, 1'b1);
      run_done = 1'b1;
   endfunction

   // Builds the text that one data byte causes and queues what the block will emit for it.
   function automatic void encode_byte(input logic [7:0] data);
      logic [7:0]  limit;
      logic [7:0]  len;
      logic [7:0]  type_sum;
      logic [7:0]  sum;
      logic [15:0] upper;
      int          emit;

      line_buf = held_text;
      held_text.delete();

      if (!run_active) begin
         run_active = 1'b1;
         run_done   = 1'b0;
         cur_addr   = cfg_base;
         bytes_left = cfg_count;
         upper_seen = 16'h0000;
         rec_left   = 8'h00;
         rec_sum    = 8'h00;
         if (bytes_left == 0) put_end_record();
      end else if (!run_done && bytes_left == 0) begin
         put_end_record();
      end

      if (!run_done && bytes_left != 0) begin
         if (rec_left == 0) begin
            limit = (cfg_max_len == 8'h00) ? 8'h01 : cfg_max_len;
            len   = (bytes_left < {24'd0, limit}) ? bytes_left[7:0] : limit;
            if (cur_addr > 32'h0000_FFFF) begin
               if (cfg_linear) begin
                  upper    = cur_addr[31:16];
                  type_sum = TYPE_SUM_LINEAR;
               end else begin
                  upper    = {cur_addr[19:16], 12'h000};
                  type_sum = TYPE_SUM_SEGMENT;
               end
               if (upper != upper_seen) begin
                  sum = type_sum + upper[7:0] + upper[15:8];
                  put_text(cfg_linear ? ":02000004" : ":02000002");
                  put_hex(upper[15:8]);
                  put_hex(upper[7:0]);
                  put_hex(8'h00 - sum);
                  put_char(CHAR_NEWLINE, 1'b0);
                  upper_seen = upper;
               end
            end
            rec_left = len;
            rec_sum  = len + cur_addr[7:0] + cur_addr[15:8];
            put_char(CHAR_COLON, 1'b0);
            put_hex(len);
            put_hex(cur_addr[15:8]);
            put_hex(cur_addr[7:0]);
            put_text("00");
         end
         put_hex(data);
         rec_sum    = rec_sum + data;
         rec_left   = rec_left - 8'd1;
         bytes_left = bytes_left - 32'd1;
         cur_addr   = cur_addr + 32'd1;
         if (rec_left == 0) begin
            put_hex(8'h00 - rec_sum);
            put_char(CHAR_NEWLINE, 1'b0);
         end
         if (bytes_left == 0) put_end_record();
      end

      // Anything past the per-byte limit is carried over to the next byte.
      emit = (line_buf.size() < MAX_CHARS_PER_BYTE) ? line_buf.size() : MAX_CHARS_PER_BYTE;
      foreach (line_buf[k]) begin
         if (k < emit) begin
            line_buf[k].last = (k == emit - 1);
            expected_text.push_back(line_buf[k]);
         end else begin
            held_text.push_back(line_buf[k]);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_base    = BASE_ADDRESS_RESET;
         cfg_linear  = ADDRESS_FORMAT_RESET;
         cfg_count   = BYTE_COUNT_RESET;
         cfg_max_len = MAX_RECORD_LEN_RESET;
         run_active  = 1'b0;
         run_done    = 1'b0;
         held_text.delete();
         expected_text.delete();
         errors      = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BASE_ADDRESS:   cfg_base    = csr_data;
               REG_ADDRESS_FORMAT: cfg_linear  = csr_data[0];
               REG_BYTE_COUNT:     cfg_count   = csr_data;
               REG_MAX_RECORD_LEN: cfg_max_len = csr_data[7:0];
               default: ;
            endcase
            run_active = 1'b0;
            run_done   = 1'b0;
            held_text.delete();
         end

         if (req_valid && req_ready) encode_byte(req_data_byte);

         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               errors++;
               $error("ascii_char: expected nothing, actual %h", rsp_ascii_char);
            end else begin
               want = expected_text.pop_front();
               if (rsp_ascii_char !== want.ch) begin
                  errors++;
                  $error("ascii_char: expected %h, actual %h", want.ch, rsp_ascii_char);
               end
               if (rsp_last_of_run !== want.last) begin
                  errors++;
                  $error("last_of_run: expected %b, actual %b", want.last, rsp_last_of_run);
               end
               if (rsp_end_of_file !== want.eof) begin
                  errors++;
                  $error("end_of_file: expected %b, actual %b", want.eof, rsp_end_of_file);
               end
            end
         end
      end
      fail_count  <= errors;
      outstanding <= expected_text.size();
   end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
   import ihex_enc_pkg::*;

   // The first character of a byte shows up after the queue, sequencer and output registers,
   // so the SETTLE_CYCLES pause covers any work still in flight for dropped bytes.
   localparam int SETTLE_CYCLES = 8;
   // The slowest legal run is far below this: a few hundred bytes, each at most 41
   // characters, each character delayed by a short random stall.
   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 310;
   localparam int STEADY_PHASE  = 4;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [6:0]             rsp_ascii_char;
   logic                   rsp_last_of_run;
   logic                   rsp_end_of_file;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index     = REG_BASE_ADDRESS;
   logic [31:0]            csr_data      = 32'd0;

   int                     fail_count;
   int                     outstanding;

   // While steady is set neither side idles, which gives one long back-to-back stretch.
   bit                     steady        = 1'b0;
   // Byte count currently programmed, so each phase knows how many bytes reach the text.
   logic [31:0]            run_count     = BYTE_COUNT_RESET;

   intel_hex_record_encoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_file (rsp_end_of_file),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   ihex_text_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_file (rsp_end_of_file),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Outside the steady phase the character sink stalls at random, about 14 percent of the time.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 14);
   end

   // Offers one data byte and returns at the edge where its transaction is accepted.
   // Random idle cycles come first, so the next valid is never dropped and raised
   // again within the same time step.
   task automatic send_byte(input logic [7:0] value);
      while (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Writes one register. Valid stays high so that writes can follow back to back;
   // the caller lowers it once the batch is done.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_BYTE_COUNT) run_count = value;
   endtask

   // Ends a phase: the input goes quiet, every expected character has to arrive, and a
   // final pause lets any dropped byte leave the block before registers are touched.
   task automatic finish_phase();
      req_valid <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int          items_done;
      int          phase;
      int          real_bytes;
      int          extra;
      logic [3:0]  mask;
      logic [31:0] value;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one byte at address zero, then a byte beyond the count.
      send_byte(8'h00);
      send_byte(8'hFF);
      finish_phase();

      // A single byte above 64K in linear format produces 42 characters. The last
      // newline is held back and comes out alone with the next byte.
      write_csr(REG_BASE_ADDRESS, 32'h0001_2345);
      write_csr(REG_ADDRESS_FORMAT, 32'd1);
      csr_valid <= 1'b0;
      send_byte(8'hA5);
      send_byte(8'h3C);
      send_byte(8'h7E);
      finish_phase();

      // A zero byte count yields only the end record, and its data byte is dropped.
      write_csr(REG_BYTE_COUNT, 32'd0);
      csr_valid <= 1'b0;
      send_byte(8'h11);
      send_byte(8'h22);
      finish_phase();

      // A zero record length acts as one, and the segment upper address rolls back to
      // zero when the address crosses the one-megabyte line.
      write_csr(REG_BASE_ADDRESS, 32'h000F_FFFE);
      write_csr(REG_ADDRESS_FORMAT, 32'd0);
      write_csr(REG_BYTE_COUNT, 32'd3);
      write_csr(REG_MAX_RECORD_LEN, 32'd0);
      csr_valid <= 1'b0;
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);
      finish_phase();

      // The address wraps past the top of the 32-bit space inside one long record.
      write_csr(REG_BASE_ADDRESS, 32'hFFFF_FFFE);
      write_csr(REG_ADDRESS_FORMAT, 32'd1);
      write_csr(REG_BYTE_COUNT, 32'd4);
      write_csr(REG_MAX_RECORD_LEN, 32'd255);
      csr_valid <= 1'b0;
      send_byte(8'h01);
      send_byte(8'hFE);
      send_byte(8'h5A);
      send_byte(8'hC3);
      send_byte(8'h99);
      finish_phase();

      // Short records start below 64K and move above it, so a segment record appears
      // in the middle of the run.
      write_csr(REG_BASE_ADDRESS, 32'h0000_FFFE);
      write_csr(REG_ADDRESS_FORMAT, 32'd0);
      write_csr(REG_BYTE_COUNT, 32'd5);
      write_csr(REG_MAX_RECORD_LEN, 32'd2);
      csr_valid <= 1'b0;
      send_byte(8'h0F);
      send_byte(8'hF0);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h00);
      finish_phase();

      // Random phases: a random subset of registers is rewritten, which starts a new
      // run, then the whole run is sent with a few surplus bytes as noise.
      items_done = 0;
      phase      = 0;
      while (items_done < RANDOM_ITEMS) begin
         phase++;
         steady = (phase == STEADY_PHASE);
         mask   = 4'($urandom_range(15, 1));

         if (mask[0]) begin
            case ($urandom_range(3))
               0:       value = $urandom_range(32'h0000_FFFF);
               1:       value = {16'($urandom), 12'hFFF, 4'($urandom)};
               2:       value = {28'hFFF_FFFF, 4'($urandom)};
               default: value = $urandom();
            endcase
            write_csr(REG_BASE_ADDRESS, value);
         end
         if (mask[1]) write_csr(REG_ADDRESS_FORMAT, {31'd0, 1'($urandom_range(1))});
         if (mask[2] || steady) begin
            case ($urandom_range(15))
               0:       value = 32'd0;
               1, 2, 3: value = $urandom_range(120, 25);
               default: value = $urandom_range(24, 1);
            endcase
            if (steady) value = 32'd96;
            write_csr(REG_BYTE_COUNT, value);
         end
         if (mask[3]) begin
            case ($urandom_range(15))
               0:          value = 32'd0;
               1:          value = 32'd255;
               2, 3, 4, 5: value = $urandom_range(255, 9);
               default:    value = $urandom_range(8, 1);
            endcase
            write_csr(REG_MAX_RECORD_LEN, value);
         end
         csr_valid <= 1'b0;

         real_bytes = (run_count == 0) ? 1 : int'(run_count);
         extra      = $urandom_range(2);
         for (int k = 0; k < real_bytes + extra; k++) send_byte(8'($urandom));
         items_done += real_bytes;
         finish_phase();
      end
      steady = 1'b0;

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[intel_hex_record_encoder.f]
+incdir+sv
sv/ihex_enc_pkg.sv
sv/ihex_enc_front.sv
sv/ihex_enc_queue.sv
sv/ihex_enc_back.sv
sv/intel_hex_record_encoder.sv
dv/ihex_text_checker.sv
dv/tb.sv
